FILE: hdl/knnbc_pkg.sv
// Shared types and constants of the k-nearest-neighbor classifier.
`timescale 1ns / 1ps

package knnbc_pkg;

  localparam int unsigned FEAT_W  = 10;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned REG_W   = 5;
  localparam int unsigned SQ_W    = 2 * FEAT_W;
  localparam int unsigned DIST_W  = SQ_W + 1;
  localparam int unsigned RAM_W   = 2 * FEAT_W + 1;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_COUNT = 1'b1;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [REG_W-1:0] POINTS_RESET    = 5'd10;
  localparam logic [REG_W-1:0] NEIGHBOURS_RESET = 5'd3;

  typedef struct packed {
    logic              opcode;
    logic [IDX_W-1:0]  point_index;
    logic [FEAT_W-1:0] feature_first;
    logic [FEAT_W-1:0] feature_second;
    logic              class_label;
  } in_t;

  typedef struct packed {
    logic             predicted_class;
    logic [REG_W-1:0] votes_class_one;
    logic [REG_W-1:0] votes_class_zero;
  } out_t;

  typedef struct packed {
    logic              valid;
    logic              label;
    logic [DIST_W-1:0] distance;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic pop;
  } ctrl_t;

endpackage

FILE: hdl/knnbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module knnbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/knnbc_dist.sv
// Two-stage squared Euclidean distance pipeline.
`timescale 1ns / 1ps

module knnbc_dist (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [knnbc_pkg::FEAT_W-1:0]        qa_i,
  input  logic [knnbc_pkg::FEAT_W-1:0]        qb_i,
  input  logic [knnbc_pkg::FEAT_W-1:0]        sa_i,
  input  logic [knnbc_pkg::FEAT_W-1:0]        sb_i,
  input  logic                                label_i,
  output logic                                valid_o,
  output logic [knnbc_pkg::DIST_W-1:0]        dist_o,
  output logic                                label_o,
  output logic                                busy_o
);

  logic                             v1_q, v2_q;
  logic                             l1_q, l2_q;
  logic [knnbc_pkg::FEAT_W-1:0]     da_q, db_q, da_d, db_d;
  logic [knnbc_pkg::SQ_W-1:0]       sqa_q, sqb_q;

  assign da_d = (sa_i >= qa_i) ? (sa_i - qa_i) : (qa_i - sa_i);
  assign db_d = (sb_i >= qb_i) ? (sb_i - qb_i) : (qb_i - sb_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    da_q  <= da_d;
    db_q  <= db_d;
    l1_q  <= label_i;
    sqa_q <= knnbc_pkg::SQ_W'(da_q) * knnbc_pkg::SQ_W'(da_q);
    sqb_q <= knnbc_pkg::SQ_W'(db_q) * knnbc_pkg::SQ_W'(db_q);
    l2_q  <= l1_q;
  end

  assign valid_o = v2_q;
  assign dist_o  = knnbc_pkg::DIST_W'(sqa_q) + knnbc_pkg::DIST_W'(sqb_q);
  assign label_o = l2_q;
  assign busy_o  = v1_q | v2_q;

endmodule

FILE: hdl/knnbc_cell.sv
// One cell of the sorted nearest-neighbor chain.
`timescale 1ns / 1ps

module knnbc_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  knnbc_pkg::ctrl_t              ctrl_i,
  input  logic [knnbc_pkg::DIST_W-1:0]  new_dist_i,
  input  logic                          new_label_i,
  input  knnbc_pkg::entry_t             left_i,
  input  logic                          left_take_i,
  input  knnbc_pkg::entry_t             right_i,
  output knnbc_pkg::entry_t             entry_o,
  output logic                          take_o
);

  logic                         valid_q, valid_d;
  logic                         label_q, label_d;
  logic [knnbc_pkg::DIST_W-1:0] dist_q, dist_d;

  // strictly closer only: equal distances keep the earlier slot ahead
  assign take_o = ctrl_i.insert && (!valid_q || (new_dist_i < dist_q));

  always_comb begin
    valid_d = valid_q;
    label_d = label_q;
    dist_d  = dist_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.pop) begin
      valid_d = right_i.valid;
      label_d = right_i.label;
      dist_d  = right_i.distance;
    end else if (left_take_i) begin
      valid_d = left_i.valid;
      label_d = left_i.label;
      dist_d  = left_i.distance;
    end else if (take_o) begin
      valid_d = 1'b1;
      label_d = new_label_i;
      dist_d  = new_dist_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    label_q <= label_d;
    dist_q  <= dist_d;
  end

  assign entry_o.valid    = valid_q;
  assign entry_o.label    = label_q;
  assign entry_o.distance = dist_q;

endmodule

FILE: hdl/knn_binary_classifier_top.sv
// Top level of the k-nearest-neighbor binary classifier.
`timescale 1ns / 1ps

// channel   | ports                                  | handshake
// ----------+----------------------------------------+----------------------------
// command   | start, busy, in_i                      | taken when start & !busy
// result    | result_valid_o, result_o               | one-cycle strobe, no stall
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i       | written when cfg_we_i high
//
// A load is written to the point memory when taken. During a classify the stored points
// stream one per cycle from the point memory through the distance pipeline into the
// cell chain, then the k nearest are popped from the head of the chain and counted.
// Reset clears control state and the chain; the point memory holds garbage until loaded.
// The result strobe lasts one cycle and cannot be stalled.

module knn_binary_classifier_top #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  knnbc_pkg::in_t                    in_i,
  output logic                              result_valid_o,
  output knnbc_pkg::out_t                   result_o,
  input  logic                              cfg_we_i,
  input  logic [knnbc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [knnbc_pkg::REG_W-1:0]       cfg_wdata_i
);

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned CELLS = (MAX_POINTS < 31) ? MAX_POINTS : 31;
  localparam int unsigned RW    = knnbc_pkg::REG_W;
  localparam int unsigned FW    = knnbc_pkg::FEAT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_VOTE
  } state_e;

  state_e                 state_q;
  logic [RW-1:0]          points_q, neigh_q;
  logic [RW-1:0]          n_q, k_q, slot_q, cnt_q, ones_q, zeros_q;
  logic [FW-1:0]          qa_q, qb_q;
  logic                   rd_v_q;
  logic                   issue;
  logic                   accept, load_we, classify;
  logic [RW-1:0]          n_eff, k_eff;
  logic [31:0]            widx_ext, slot_ext;
  logic [AW-1:0]          waddr, raddr;
  logic [knnbc_pkg::RAM_W-1:0] wdata, rdata;
  logic                   d_valid, d_label, d_busy;
  logic [knnbc_pkg::DIST_W-1:0] d_dist;
  knnbc_pkg::ctrl_t       ctrl;
  knnbc_pkg::entry_t      cell_e [CELLS];
  knnbc_pkg::entry_t      left_e [CELLS];
  knnbc_pkg::entry_t      right_e [CELLS];
  logic                   take [CELLS];
  logic                   left_take [CELLS];
  knnbc_pkg::out_t        result_q;
  logic                   result_valid_q;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign classify = accept && (in_i.opcode == knnbc_pkg::OP_CLASSIFY);

  assign widx_ext = 32'(in_i.point_index);
  assign waddr    = widx_ext[AW-1:0];
  assign load_we  = accept && (in_i.opcode == knnbc_pkg::OP_LOAD) && (widx_ext < MAX_POINTS);
  assign wdata    = {in_i.class_label, in_i.feature_first, in_i.feature_second};

  assign n_eff = (32'(points_q) > MAX_POINTS) ? RW'(MAX_POINTS) : points_q;
  assign k_eff = (neigh_q > n_eff) ? n_eff : neigh_q;

  assign slot_ext = 32'(slot_q);
  assign raddr    = slot_ext[AW-1:0];
  assign issue    = (state_q == S_SCAN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= knnbc_pkg::POINTS_RESET;
      neigh_q  <= knnbc_pkg::NEIGHBOURS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        knnbc_pkg::REG_POINTS_IN_USE:   points_q <= cfg_wdata_i;
        knnbc_pkg::REG_NEIGHBOUR_COUNT: neigh_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  knnbc_ram #(
    .WIDTH (knnbc_pkg::RAM_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  knnbc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_v_q),
    .qa_i    (qa_q),
    .qb_i    (qb_q),
    .sa_i    (rdata[2*FW-1:FW]),
    .sb_i    (rdata[FW-1:0]),
    .label_i (rdata[2*FW]),
    .valid_o (d_valid),
    .dist_o  (d_dist),
    .label_o (d_label),
    .busy_o  (d_busy)
  );

  assign ctrl.clear  = classify;
  assign ctrl.insert = d_valid;
  assign ctrl.pop    = (state_q == S_VOTE) && (cnt_q != k_q);

  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign left_e[j]    = '0;
      assign left_take[j] = 1'b0;
    end else begin : g_body
      assign left_e[j]    = cell_e[j-1];
      assign left_take[j] = take[j-1];
    end
    if (j == CELLS - 1) begin : g_tail
      assign right_e[j] = '0;
    end else begin : g_mid
      assign right_e[j] = cell_e[j+1];
    end

    knnbc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_dist_i  (d_dist),
      .new_label_i (d_label),
      .left_i      (left_e[j]),
      .left_take_i (left_take[j]),
      .right_i     (right_e[j]),
      .entry_o     (cell_e[j]),
      .take_o      (take[j])
    );
  end

  always_ff @(posedge clk_i) begin
    if (classify) begin
      qa_q <= in_i.feature_first;
      qb_q <= in_i.feature_second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      n_q            <= '0;
      k_q            <= '0;
      slot_q         <= '0;
      cnt_q          <= '0;
      ones_q         <= '0;
      zeros_q        <= '0;
      rd_v_q         <= 1'b0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      rd_v_q         <= issue;
      result_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (classify) begin
            n_q     <= n_eff;
            k_q     <= k_eff;
            slot_q  <= '0;
            cnt_q   <= '0;
            ones_q  <= '0;
            zeros_q <= '0;
            state_q <= (n_eff == '0) ? S_VOTE : S_SCAN;
          end
        end
        S_SCAN: begin
          slot_q <= slot_q + 1'b1;
          if (slot_q == n_q - 1'b1) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v_q && !d_busy) begin
            state_q <= S_VOTE;
          end
        end
        S_VOTE: begin
          if (cnt_q == k_q) begin
            result_valid_q            <= 1'b1;
            result_q.predicted_class  <= (ones_q > zeros_q);
            result_q.votes_class_one  <= ones_q;
            result_q.votes_class_zero <= zeros_q;
            state_q                   <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
            if (cell_e[0].valid) begin
              if (cell_e[0].label) begin
                ones_q <= ones_q + 1'b1;
              end else begin
                zeros_q <= zeros_q + 1'b1;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

FILE: dv/knn_binary_classifier_top_test.sv
// Self-checking testbench of the k-nearest-neighbor binary classifier top level.
`timescale 1ns / 1ps

module knn_binary_classifier_top_test;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned SETTLE      = 48;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 172;
  localparam int unsigned FW          = knnbc_pkg::FEAT_W;
  localparam int unsigned RW          = knnbc_pkg::REG_W;
  localparam int unsigned CW          = knnbc_pkg::CFG_IDX_W;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  knnbc_pkg::in_t    in_i        = '0;
  logic              result_valid_o;
  knnbc_pkg::out_t   result_o;
  logic              cfg_we_i    = 1'b0;
  logic [CW-1:0]     cfg_idx_i   = knnbc_pkg::REG_POINTS_IN_USE;
  logic [RW-1:0]     cfg_wdata_i = '0;

  logic [FW-1:0] pt_f1  [SLOTS];
  logic [FW-1:0] pt_f2  [SLOTS];
  logic          pt_lbl [SLOTS];
  logic [RW-1:0] cfg_points = knnbc_pkg::POINTS_RESET;
  logic [RW-1:0] cfg_k      = knnbc_pkg::NEIGHBOURS_RESET;

  knnbc_pkg::in_t  cmd_q  [$];
  knnbc_pkg::out_t vote_q [$];
  knnbc_pkg::out_t want;

  bit          idle_on   = 1'b1;
  int unsigned gap_left  = 0;
  int unsigned issued    = 0;
  int unsigned accepted  = 0;
  int unsigned loads     = 0;
  int unsigned queries   = 0;
  int unsigned checked   = 0;
  int unsigned settings  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt   = 0;

  knn_binary_classifier_top #(
    .MAX_POINTS(SLOTS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic knnbc_pkg::out_t predict_vote(logic [FW-1:0] qa, logic [FW-1:0] qb);
    int unsigned     sq_d [SLOTS];
    int unsigned     n, k, rank, ones, zeros;
    int              da, db;
    knnbc_pkg::out_t r;
    n     = (cfg_points > SLOTS) ? SLOTS : cfg_points;
    k     = (cfg_k > n) ? n : cfg_k;
    ones  = 0;
    zeros = 0;
    for (int i = 0; i < n; i++) begin
      da      = int'(pt_f1[i]) - int'(qa);
      db      = int'(pt_f2[i]) - int'(qb);
      sq_d[i] = da * da + db * db;
    end
    for (int i = 0; i < n; i++) begin
      rank = 0;
      for (int j = 0; j < n; j++) begin
        if (sq_d[j] < sq_d[i] || (sq_d[j] == sq_d[i] && j < i)) rank++;
      end
      if (rank < k) begin
        if (pt_lbl[i]) ones++;
        else zeros++;
      end
    end
    r.predicted_class  = (ones > zeros);
    r.votes_class_one  = RW'(ones);
    r.votes_class_zero = RW'(zeros);
    return r;
  endfunction

  function automatic void take_cmd(knnbc_pkg::in_t c);
    accepted++;
    if (c.opcode == knnbc_pkg::OP_LOAD) begin
      pt_f1[c.point_index]  = c.feature_first;
      pt_f2[c.point_index]  = c.feature_second;
      pt_lbl[c.point_index] = c.class_label;
      loads++;
    end else begin
      vote_q.push_back(predict_vote(c.feature_first, c.feature_second));
      queries++;
    end
  endfunction

  function automatic logic [FW-1:0] rand_feat(logic [FW-1:0] center);
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return $urandom_range(0, 1) ? {FW{1'b1}} : '0;
    if (sel < 4) return center + FW'($urandom_range(0, 3));
    return FW'($urandom_range(0, 1023));
  endfunction

  function automatic knnbc_pkg::in_t rand_cmd(logic [FW-1:0] center);
    knnbc_pkg::in_t c;
    c.opcode         = ($urandom_range(0, 9) < 4) ? knnbc_pkg::OP_LOAD
                                                  : knnbc_pkg::OP_CLASSIFY;
    c.point_index    = knnbc_pkg::IDX_W'($urandom_range(0, 15));
    c.feature_first  = rand_feat(center);
    c.feature_second = rand_feat(center);
    c.class_label    = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic push_cmd(logic op, int unsigned idx, int unsigned f1, int unsigned f2,
                          logic lbl);
    knnbc_pkg::in_t c;
    c.opcode         = op;
    c.point_index    = knnbc_pkg::IDX_W'(idx);
    c.feature_first  = FW'(f1);
    c.feature_second = FW'(f2);
    c.class_label    = lbl;
    cmd_q.push_back(c);
    issued++;
  endtask

  task automatic drain();
    while (accepted != issued || vote_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CW-1:0] idx, logic [RW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == knnbc_pkg::REG_POINTS_IN_USE) cfg_points = val;
    else cfg_k = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int unsigned pts, int unsigned k);
    logic [FW-1:0] center;
    center = FW'($urandom_range(0, 1020));
    write_cfg(knnbc_pkg::REG_POINTS_IN_USE, RW'(pts));
    write_cfg(knnbc_pkg::REG_NEIGHBOUR_COUNT, RW'(k));
    settings++;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      cmd_q.push_back(rand_cmd(center));
      issued++;
    end
    drain();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) take_cmd(in_i);
      if (!start || !busy) begin
        if (gap_left == 0 && idle_on && cmd_q.size() != 0 && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 10);
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          in_i  <= cmd_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (vote_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with no transaction pending, actual %p", $time, result_o);
      end else begin
        want = vote_q.pop_front();
        checked++;
        if (result_o.predicted_class !== want.predicted_class) begin
          err_cnt++;
          $display("%0t: predicted_class expected %0d actual %0d", $time,
                   want.predicted_class, result_o.predicted_class);
        end
        if (result_o.votes_class_one !== want.votes_class_one) begin
          err_cnt++;
          $display("%0t: votes_class_one expected %0d actual %0d", $time,
                   want.votes_class_one, result_o.votes_class_one);
        end
        if (result_o.votes_class_zero !== want.votes_class_zero) begin
          err_cnt++;
          $display("%0t: votes_class_zero expected %0d actual %0d", $time,
                   want.votes_class_zero, result_o.votes_class_zero);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned fix_pts [7];
    int unsigned fix_k   [7];
    fix_pts = '{16, 1, 0, 31, 16, 5, 8};
    fix_k   = '{16, 1, 5, 31, 0, 31, 4};
    for (int i = 0; i < SLOTS; i++) begin
      pt_f1[i]  = '0;
      pt_f2[i]  = '0;
      pt_lbl[i] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every slot, then query under the reset register values
    push_cmd(knnbc_pkg::OP_LOAD, 0, 0, 0, 1'b0);
    push_cmd(knnbc_pkg::OP_LOAD, 1, 1023, 1023, 1'b1);
    push_cmd(knnbc_pkg::OP_LOAD, 2, 0, 1023, 1'b1);
    push_cmd(knnbc_pkg::OP_LOAD, 3, 1023, 0, 1'b0);
    push_cmd(knnbc_pkg::OP_LOAD, 4, 512, 512, 1'b1);
    push_cmd(knnbc_pkg::OP_LOAD, 5, 512, 512, 1'b0);
    push_cmd(knnbc_pkg::OP_LOAD, 6, 511, 513, 1'b1);
    push_cmd(knnbc_pkg::OP_LOAD, 7, 513, 511, 1'b0);
    push_cmd(knnbc_pkg::OP_LOAD, 8, 100, 900, 1'b1);
    push_cmd(knnbc_pkg::OP_LOAD, 9, 900, 100, 1'b0);
    push_cmd(knnbc_pkg::OP_LOAD, 10, 341, 682, 1'b1);
    push_cmd(knnbc_pkg::OP_LOAD, 11, 682, 341, 1'b0);
    for (int i = 12; i < SLOTS; i++) push_cmd(knnbc_pkg::OP_LOAD, i, 10 + i, 20 + i, i[0]);
    push_cmd(knnbc_pkg::OP_CLASSIFY, 15, 512, 512, 1'b1);
    push_cmd(knnbc_pkg::OP_CLASSIFY, 0, 0, 0, 1'b0);
    push_cmd(knnbc_pkg::OP_CLASSIFY, 10, 1023, 1023, 1'b1);
    push_cmd(knnbc_pkg::OP_CLASSIFY, 5, 1023, 0, 1'b0);
    push_cmd(knnbc_pkg::OP_CLASSIFY, 15, 341, 682, 1'b1);
    drain();
    settings++;

    for (int p = 0; p < 7; p++) run_phase(fix_pts[p], fix_k[p]);
    for (int p = 0; p < 3; p++) run_phase($urandom_range(0, 31), $urandom_range(0, 31));
    idle_on = 1'b0;
    run_phase($urandom_range(1, 16), $urandom_range(1, 16));

    $display("Ran %0d loads and %0d classifications over %0d register settings, %0d checked.",
             loads, queries, settings, checked);
    $display("Settings spanned zero, saturated and oversized k and point counts with ties.");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
